>>> design/sbpt_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the second-boundary prewarm timer
// no dependencies; every module of the block imports this package
package sbpt_pkg;

    localparam int TIME_W    = 63;
    localparam int WIDE_W    = 64;
    localparam int HALF_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int LEAD_C_W  = 13;
    localparam int NS_W      = 23;
    localparam int REM_W     = 30;

    localparam logic [LEAD_C_W-1:0] LEAD_MIN_US   = LEAD_C_W'(60);
    localparam logic [LEAD_C_W-1:0] LEAD_MAX_US   = LEAD_C_W'(5000);
    localparam logic [LEAD_C_W-1:0] MARGIN_MIN_US = LEAD_C_W'(10);
    localparam logic [NS_W-1:0]     NS_PER_US     = NS_W'(1000);
    localparam logic [REM_W-1:0]    NS_PER_S      = REM_W'(1000000000);

    // 2^32 mod one second, and minus one second in 64-bit two's complement
    localparam logic [HALF_W-1:0]   FOLD_K        = HALF_W'(294967296);
    localparam logic [WIDE_W-1:0]   NS_PER_S_NEG  = ~WIDE_W'(1000000000) + WIDE_W'(1);

    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_US    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_US  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_ENABLE = CFG_IDX_W'(2);

    localparam logic KIND_START  = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [TIME_W-1:0] now_ns;
    } in_t;

    typedef struct packed {
        logic                     warm_pulse;
        logic                     skipped;
        logic signed [WIDE_W-1:0] lateness_ns;
        logic [TIME_W-1:0]        next_expiry_ns;
        logic [TIME_W-1:0]        worst_lateness_ns;
        logic [WIDE_W-1:0]        pulse_count;
        logic [WIDE_W-1:0]        skip_count;
    } out_t;

    // clamped settings in nanoseconds
    typedef struct packed {
        logic [NS_W-1:0] lead_ns;
        logic [NS_W-1:0] thr_ns;
        logic            arm;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WRAP
    } seq_state_t;

endpackage

>>> design/sbpt_cfg.sv
`timescale 1ns / 1ps
// configuration registers with lead and margin clamping
// depends on sbpt_pkg
module sbpt_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sbpt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sbpt_pkg::CFG_W-1:0]      cfg_data,
    output sbpt_pkg::cfg_t                  cfg
);
    import sbpt_pkg::*;

    logic [CFG_W-1:0]    lead_reg;
    logic [CFG_W-1:0]    margin_reg;
    logic                arm_reg;
    logic [LEAD_C_W-1:0] lead_c;
    logic [LEAD_C_W-1:0] margin_hi;
    logic [CFG_W-1:0]    margin_lo;
    logic [LEAD_C_W-1:0] margin_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg   <= CFG_W'(150);
            margin_reg <= CFG_W'(30);
            arm_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LEAD_US:    lead_reg   <= cfg_data;
                CFG_MARGIN_US:  margin_reg <= cfg_data;
                CFG_ARM_ENABLE: arm_reg    <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        if (lead_reg < CFG_W'(LEAD_MIN_US))
            lead_c = LEAD_MIN_US;
        else if (lead_reg > CFG_W'(LEAD_MAX_US))
            lead_c = LEAD_MAX_US;
        else
            lead_c = lead_reg[LEAD_C_W-1:0];

        margin_hi = lead_c - MARGIN_MIN_US;
        margin_lo = (margin_reg < CFG_W'(MARGIN_MIN_US)) ? CFG_W'(MARGIN_MIN_US) : margin_reg;
        if (margin_lo > CFG_W'(margin_hi))
            margin_c = margin_hi;
        else
            margin_c = margin_lo[LEAD_C_W-1:0];

        cfg.lead_ns = NS_W'(lead_c) * NS_PER_US;
        // margin never exceeds lead, so the difference stays positive
        cfg.thr_ns  = NS_W'(lead_c - margin_c) * NS_PER_US;
        cfg.arm     = arm_reg;
    end

endmodule

>>> design/sbpt_div.sv
`timescale 1ns / 1ps
// iterative remainder unit: 64-bit dividend modulo one second by folding the upper word
// back in with 2^32 mod 1e9, then subtracting one second; depends on sbpt_pkg
module sbpt_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sbpt_pkg::WIDE_W-1:0]   dividend,
    output logic                          busy,
    output logic [sbpt_pkg::REM_W-1:0]    rem
);
    import sbpt_pkg::*;

    logic [WIDE_W-1:0] acc_reg;
    logic [WIDE_W-1:0] acc_next;
    logic              busy_reg;
    logic              busy_next;
    logic              folding;
    logic              fits;
    logic [WIDE_W-1:0] fold_prod;
    logic [WIDE_W-1:0] add_a;
    logic [WIDE_W-1:0] add_b;
    logic [WIDE_W-1:0] add_sum;

    // at most 11 folds bring the value below 2^32, then at most 4 subtracts
    assign folding   = (acc_reg[WIDE_W-1:HALF_W] != '0);
    assign fits      = (acc_reg >= WIDE_W'(NS_PER_S));
    // both operands fit in 32 bits
    assign fold_prod = WIDE_W'(acc_reg[WIDE_W-1:HALF_W]) * WIDE_W'(FOLD_K);

    // one adder shared by the fold and the subtract steps
    always_comb
    begin
        if (folding)
        begin
            add_a = fold_prod;
            add_b = WIDE_W'(acc_reg[HALF_W-1:0]);
        end
        else
        begin
            add_a = acc_reg;
            add_b = NS_PER_S_NEG;
        end
    end

    assign add_sum = add_a + add_b;

    always_comb
    begin
        acc_next  = acc_reg;
        busy_next = busy_reg;
        if (start)
        begin
            acc_next  = dividend;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (folding || fits)
                acc_next = add_sum;
            else
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign busy = busy_reg;
    assign rem  = acc_reg[REM_W-1:0];

endmodule

>>> design/second_boundary_prewarm_timer.sv
`timescale 1ns / 1ps
// top level of the second-boundary prewarm timer: sequencer, schedule state, output register
// depends on sbpt_pkg, sbpt_cfg and sbpt_div
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------
//  in      | in_valid / in_stall  | in_data  (sbpt_pkg::in_t)
//  out     | out_valid / out_stall| out_data (sbpt_pkg::out_t)
//  cfg     | cfg_we               | cfg_index, cfg_data
//
// one transaction runs from accept through up to 11 fold and 4 subtract steps in the
// shared remainder unit that reduces now + lead modulo one second, the step in which the
// unit clears busy, the move to commit and the commit, which waits while out_stall holds
// the output register; the result enters the output register when ST_WRAP commits.
// in_stall is high from capture until the result moves into the output register,
// which then holds it while out_stall is high; the next transaction is taken meanwhile.
// rst_n clears the schedule, the counters, the sequencer and out_valid.
module second_boundary_prewarm_timer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  sbpt_pkg::in_t                   in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output sbpt_pkg::out_t                  out_data,
    input  logic                            cfg_we,
    input  logic [sbpt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sbpt_pkg::CFG_W-1:0]      cfg_data
);
    import sbpt_pkg::*;

    cfg_t              cfg;
    seq_state_t        state_reg;
    seq_state_t        state_next;
    logic              accept;
    logic              div_start;
    logic              div_busy;
    logic [REM_W-1:0]  div_rem;
    logic              out_free;
    logic              commit;

    logic              kind_reg;
    logic [WIDE_W-1:0] late_reg;
    logic [WIDE_W-1:0] base_reg;
    logic [WIDE_W-1:0] expiry_reg;
    logic [TIME_W-1:0] worst_reg;
    logic [WIDE_W-1:0] pulses_reg;
    logic [WIDE_W-1:0] skips_reg;
    logic              out_valid_reg;
    out_t              out_reg;

    logic [WIDE_W-1:0] now_ext;
    logic [WIDE_W-1:0] expiry_next;
    logic [TIME_W-1:0] worst_next;
    logic [WIDE_W-1:0] pulses_next;
    logic [WIDE_W-1:0] skips_next;
    logic              late_neg;
    logic              do_pulse;
    logic              do_skip;

    sbpt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign now_ext = {1'b0, in_data.now_ns};

    sbpt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (now_ext + WIDE_W'(cfg.lead_ns)),
        .busy     (div_busy),
        .rem      (div_rem)
    );

    assign out_free = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid)  state_next = ST_DIV;
            ST_DIV:  if (!div_busy) state_next = ST_WRAP;
            ST_WRAP: if (out_free)  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall = 1'b1;
        commit   = 1'b0;
        case (state_reg)
            ST_IDLE: in_stall = 1'b0;
            ST_WRAP: commit   = out_free;
            default: ;
        endcase
    end

    assign accept    = in_valid && !in_stall;
    assign div_start = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= in_data.kind;
            late_reg <= (in_data.kind == KIND_EXPIRY) ? now_ext - expiry_reg : '0;
            base_reg <= now_ext + WIDE_W'(NS_PER_S);
        end
    end

    // decision and new schedule; expiry = now + 1s - ((now + lead) mod 1s)
    always_comb
    begin
        late_neg    = late_reg[WIDE_W-1];
        do_pulse    = 1'b0;
        do_skip     = 1'b0;
        worst_next  = worst_reg;
        expiry_next = base_reg - WIDE_W'(div_rem);
        if (kind_reg == KIND_EXPIRY)
        begin
            if (!late_neg && (late_reg[TIME_W-1:0] > worst_reg))
                worst_next = late_reg[TIME_W-1:0];
            if (cfg.arm)
            begin
                if (late_neg || (late_reg < WIDE_W'(cfg.thr_ns)))
                    do_pulse = 1'b1;
                else
                    do_skip = 1'b1;
            end
        end
        pulses_next = pulses_reg + WIDE_W'(do_pulse);
        skips_next  = skips_reg + WIDE_W'(do_skip);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expiry_reg <= '0;
            worst_reg  <= '0;
            pulses_reg <= '0;
            skips_reg  <= '0;
        end
        else if (commit)
        begin
            expiry_reg <= expiry_next;
            worst_reg  <= worst_next;
            pulses_reg <= pulses_next;
            skips_reg  <= skips_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (commit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_reg.warm_pulse        <= do_pulse;
            out_reg.skipped           <= do_skip;
            out_reg.lateness_ns       <= late_reg;
            out_reg.next_expiry_ns    <= expiry_next[TIME_W-1:0];
            out_reg.worst_lateness_ns <= worst_next;
            out_reg.pulse_count       <= pulses_next;
            out_reg.skip_count        <= skips_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
